[src/jasf_pkg.sv]
`timescale 1ns / 1ps

package jasf_pkg;

   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [7:0] MARKER_SOI    = 8'hD8;
   localparam logic [7:0] MARKER_EOI    = 8'hD9;
   localparam logic [7:0] WANTED_MARKER_RESET = 8'hE2;
   localparam logic [3:0] MAX_MAGIC_BYTES     = 4'd12;
   localparam logic [3:0] MAGIC_COUNT_RESET   = 4'd12;

   typedef enum logic [2:0] {
      OUTCOME_FOUND      = 3'd0,
      OUTCOME_NO_PREFIX  = 3'd1,
      OUTCOME_EOI        = 3'd2,
      OUTCOME_BUFFER_END = 3'd3,
      OUTCOME_REJECTED   = 3'd4
   } outcome_type;

   typedef enum logic [1:0] {
      REG_WANTED_MARKER = 2'd0,
      REG_MAGIC_FIRST   = 2'd1,
      REG_MAGIC_LAST    = 2'd2,
      REG_MAGIC_COUNT   = 2'd3
   } reg_index_type;

   typedef enum logic [5:0] {
      PH_PREFIX = 6'b000001,
      PH_TYPE   = 6'b000010,
      PH_LEN_HI = 6'b000100,
      PH_LEN_LO = 6'b001000,
      PH_BODY   = 6'b010000,
      PH_WAIT   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0]  wanted_marker;
      logic [63:0] magic_first_bytes;
      logic [31:0] magic_last_bytes;
      logic [3:0]  magic_count;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      outcome_type outcome;
      logic [23:0] payload_offset;
      logic [15:0] payload_length;
   } rsp_beat_type;

   typedef struct packed {
      logic         valid;
      rsp_beat_type beat;
   } result_type;

   function automatic logic [7:0] magic_byte(input logic [63:0] first,
                                             input logic [31:0] last,
                                             input logic [3:0]  idx);
      logic [7:0] b;
      b = 8'h00;
      if (idx < 4'd8) begin
         b = first[8 * (3'd7 - idx[2:0]) +: 8];
      end else if (idx < 4'd12) begin
         b = last[8 * (2'd3 - idx[1:0]) +: 8];
      end
      return b;
   endfunction

   function automatic logic [3:0] active_magic_count(input logic [3:0] count);
      logic [3:0] m;
      m = count;
      if (m > MAX_MAGIC_BYTES) begin
         m = MAX_MAGIC_BYTES;
      end
      return m;
   endfunction

endpackage

[src/jasf_req_if.sv]
`timescale 1ns / 1ps

interface jasf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[src/jasf_rsp_if.sv]
`timescale 1ns / 1ps

interface jasf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  outcome;
   logic [23:0] payload_offset;
   logic [15:0] payload_length;

   modport source (output valid, output outcome, output payload_offset,
                   output payload_length, input ready);
   modport sink (input valid, input outcome, input payload_offset,
                 input payload_length, output ready);
endinterface

[src/jasf_csr_regs.sv]
`timescale 1ns / 1ps

module jasf_csr_regs (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_write_data,
   output jasf_pkg::cfg_type cfg
);

   jasf_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            jasf_pkg::REG_WANTED_MARKER: cfg_in.wanted_marker = csr_write_data[7:0];
            jasf_pkg::REG_MAGIC_FIRST:   cfg_in.magic_first_bytes = csr_write_data;
            jasf_pkg::REG_MAGIC_LAST:    cfg_in.magic_last_bytes = csr_write_data[31:0];
            jasf_pkg::REG_MAGIC_COUNT:   cfg_in.magic_count = csr_write_data[3:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wanted_marker     <= jasf_pkg::WANTED_MARKER_RESET;
         cfg_ff.magic_first_bytes <= '0;
         cfg_ff.magic_last_bytes  <= '0;
         cfg_ff.magic_count       <= jasf_pkg::MAGIC_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/jasf_in_reg.sv]
`timescale 1ns / 1ps

module jasf_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  jasf_pkg::req_beat_type req_beat,
   output logic                   req_ready,
   input  logic                   advance,
   output logic                   in_valid,
   output jasf_pkg::req_beat_type in_beat
);

   logic                   valid_ff, valid_in;
   jasf_pkg::req_beat_type beat_ff;
   logic                   take;

   assign req_ready = !reset && (!valid_ff || advance);
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         beat_ff <= req_beat;
      end
   end

   assign in_valid = valid_ff;
   assign in_beat  = beat_ff;

endmodule

[src/jasf_walker.sv]
`timescale 1ns / 1ps

module jasf_walker #(
   parameter longint unsigned MAX_BUFFER_BYTES = 64'd16777216
) (
   input  logic                   clock,
   input  logic                   reset,
   input  jasf_pkg::cfg_type      cfg,
   input  logic                   step,
   input  jasf_pkg::req_beat_type beat,
   output jasf_pkg::result_type   result,
   output logic                   answered
);

   localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 64'd1);
   localparam int SEG_W = POS_W + 1;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_BUFFER_BYTES);

   logic [POS_W-1:0]      pos_ff, pos_in;
   jasf_pkg::phase_type   phase_ff, phase_in;
   logic [SEG_W-1:0]      mark_ff, mark_in;
   logic [7:0]            len_hi_ff, len_hi_in;
   logic [15:0]           len_ff, len_in;
   logic [23:0]           offset_ff, offset_in;
   logic [3:0]            idx_ff, idx_in;
   logic                  wanted_ff, wanted_in;
   logic                  answered_ff, answered_in;
   jasf_pkg::outcome_type pending_ff, pending_in;

   logic [SEG_W-1:0]      pos_ext;
   logic                  hit;
   logic                  examine_en;
   logic [15:0]           field;
   logic [3:0]            mlen;
   logic [7:0]            b;
   logic [7:0]            wm;
   logic                  emit;
   jasf_pkg::outcome_type emit_outcome;
   logic [23:0]           emit_offset;
   logic [15:0]           emit_length;

   assign b          = beat.data_byte;
   assign wm         = cfg.wanted_marker;
   assign pos_ext    = SEG_W'(pos_ff);
   assign hit        = (pos_ext == mark_ff);
   assign examine_en = !answered_ff && (pos_ff != POS_LIMIT);
   assign field      = {len_hi_ff, b};
   assign mlen       = jasf_pkg::active_magic_count(cfg.magic_count);

   always_comb begin
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      mark_in      = mark_ff;
      len_hi_in    = len_hi_ff;
      len_in       = len_ff;
      offset_in    = offset_ff;
      idx_in       = idx_ff;
      wanted_in    = wanted_ff;
      answered_in  = answered_ff;
      pending_in   = pending_ff;
      emit         = 1'b0;
      emit_outcome = jasf_pkg::OUTCOME_FOUND;
      emit_offset  = '0;
      emit_length  = '0;
      if (step) begin
         if (pos_ff != POS_LIMIT) begin
            pos_in = pos_ff + 1'b1;
         end
         if (examine_en) begin
            if (pos_ff == '0 && wm == 8'h00) begin
               emit         = 1'b1;
               emit_outcome = jasf_pkg::OUTCOME_REJECTED;
            end else begin
               case (phase_ff)
                  jasf_pkg::PH_PREFIX: begin
                     if (hit) begin
                        if (b != jasf_pkg::MARKER_PREFIX) begin
                           pending_in = jasf_pkg::OUTCOME_NO_PREFIX;
                           mark_in    = pos_ext + SEG_W'(2);
                           phase_in   = jasf_pkg::PH_WAIT;
                        end else begin
                           phase_in = jasf_pkg::PH_TYPE;
                        end
                     end
                  end
                  jasf_pkg::PH_TYPE: begin
                     if (b == wm) begin
                        if (b == jasf_pkg::MARKER_SOI || b == jasf_pkg::MARKER_EOI) begin
                           pending_in = jasf_pkg::OUTCOME_REJECTED;
                           mark_in    = pos_ext + SEG_W'(1);
                           phase_in   = jasf_pkg::PH_WAIT;
                        end else begin
                           wanted_in = 1'b1;
                           phase_in  = jasf_pkg::PH_LEN_HI;
                        end
                     end else if (b == jasf_pkg::MARKER_EOI) begin
                        pending_in = jasf_pkg::OUTCOME_EOI;
                        mark_in    = pos_ext + SEG_W'(1);
                        phase_in   = jasf_pkg::PH_WAIT;
                     end else if (b == jasf_pkg::MARKER_SOI) begin
                        mark_in  = pos_ext + SEG_W'(1);
                        phase_in = jasf_pkg::PH_PREFIX;
                     end else begin
                        wanted_in = 1'b0;
                        phase_in  = jasf_pkg::PH_LEN_HI;
                     end
                  end
                  jasf_pkg::PH_LEN_HI: begin
                     len_hi_in = b;
                     phase_in  = jasf_pkg::PH_LEN_LO;
                  end
                  jasf_pkg::PH_LEN_LO: begin
                     if (wanted_ff) begin
                        if (field < ({12'h000, mlen} + 16'd2)) begin
                           pending_in = jasf_pkg::OUTCOME_REJECTED;
                           mark_in    = pos_ext + SEG_W'(1);
                           phase_in   = jasf_pkg::PH_WAIT;
                        end else begin
                           idx_in    = '0;
                           mark_in   = pos_ext + SEG_W'(field) - SEG_W'(1);
                           offset_in = 24'(pos_ext + SEG_W'(1));
                           len_in    = field - 16'd2;
                           phase_in  = jasf_pkg::PH_BODY;
                        end
                     end else if (field <= 16'd1) begin
                        // next segment would start inside the length bytes
                        pending_in = jasf_pkg::OUTCOME_NO_PREFIX;
                        mark_in    = pos_ext + SEG_W'(field) + SEG_W'(1);
                        phase_in   = jasf_pkg::PH_WAIT;
                     end else begin
                        mark_in  = pos_ext + SEG_W'(field) - SEG_W'(1);
                        phase_in = jasf_pkg::PH_PREFIX;
                     end
                  end
                  jasf_pkg::PH_BODY: begin
                     if (hit) begin
                        emit         = 1'b1;
                        emit_outcome = jasf_pkg::OUTCOME_FOUND;
                        emit_offset  = offset_ff;
                        emit_length  = len_ff;
                     end else if (idx_ff < mlen && b != jasf_pkg::magic_byte(
                                  cfg.magic_first_bytes, cfg.magic_last_bytes, idx_ff)) begin
                        emit         = 1'b1;
                        emit_outcome = jasf_pkg::OUTCOME_REJECTED;
                     end
                     if (idx_ff != 4'hF) begin
                        idx_in = idx_ff + 4'd1;
                     end
                  end
                  jasf_pkg::PH_WAIT: begin
                     if (hit) begin
                        emit         = 1'b1;
                        emit_outcome = pending_ff;
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end
         end
         if (beat.last_byte && !answered_ff && !emit) begin
            emit         = 1'b1;
            emit_outcome = jasf_pkg::OUTCOME_BUFFER_END;
         end
         answered_in = answered_ff || emit;
         if (beat.last_byte) begin
            pos_in      = '0;
            phase_in    = jasf_pkg::PH_PREFIX;
            mark_in     = '0;
            len_hi_in   = '0;
            len_in      = '0;
            offset_in   = '0;
            idx_in      = '0;
            wanted_in   = 1'b0;
            answered_in = 1'b0;
            pending_in  = jasf_pkg::OUTCOME_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         phase_ff    <= jasf_pkg::PH_PREFIX;
         mark_ff     <= '0;
         wanted_ff   <= 1'b0;
         answered_ff <= 1'b0;
         pending_ff  <= jasf_pkg::OUTCOME_FOUND;
         idx_ff      <= '0;
      end else begin
         pos_ff      <= pos_in;
         phase_ff    <= phase_in;
         mark_ff     <= mark_in;
         wanted_ff   <= wanted_in;
         answered_ff <= answered_in;
         pending_ff  <= pending_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      len_hi_ff <= len_hi_in;
      len_ff    <= len_in;
      offset_ff <= offset_in;
   end

   assign result.valid               = step && emit;
   assign result.beat.outcome        = emit_outcome;
   assign result.beat.payload_offset = emit_offset;
   assign result.beat.payload_length = emit_length;
   assign answered                   = answered_ff;

endmodule

[src/jasf_out_reg.sv]
`timescale 1ns / 1ps

module jasf_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  jasf_pkg::result_type   result,
   input  logic                   rsp_ready,
   output logic                   advance,
   output logic                   rsp_valid,
   output jasf_pkg::rsp_beat_type rsp_beat
);

   logic                   valid_ff, valid_in;
   jasf_pkg::rsp_beat_type beat_ff;

   assign advance = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         beat_ff <= result.beat;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

endmodule

[src/jpeg_app_segment_finder_unit.sv]
`timescale 1ns / 1ps

// Walks the marker chain of a JPEG buffer streamed one byte per req beat and
// gives exactly one rsp beat per buffer (found offset/length or a failure
// code); bytes after the answer are swallowed up to the last_byte beat.
// Throughput is one byte per clock while no held answer waits: the input
// register feeds a parse step of position adds and compares, and an output
// register holds the answer until rsp takes it. rsp valid rises once the
// deciding byte has passed the input register and the answer is registered
// in the output register. The pipe stalls only while a held answer is not
// taken. Registers must be written only while idle; the block does not check.

module jpeg_app_segment_finder_unit #(
   parameter longint unsigned MAX_BUFFER_BYTES = 64'd16777216
) (
   input  logic              clock,
   input  logic              reset,
   jasf_req_if.sink          req_chan,
   jasf_rsp_if.source        rsp_chan,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_write_data
);

   jasf_pkg::cfg_type      cfg;
   jasf_pkg::req_beat_type req_beat;
   jasf_pkg::req_beat_type in_beat;
   jasf_pkg::result_type   walker_result;
   jasf_pkg::rsp_beat_type rsp_beat;
   logic                   in_valid;
   logic                   advance;
   logic                   step;
   logic                   walker_answered;
   logic                   req_ready;
   logic                   rsp_valid;

   assign req_beat.data_byte = req_chan.data_byte;
   assign req_beat.last_byte = req_chan.last_byte;
   assign req_chan.ready     = req_ready;
   assign step               = in_valid && advance;

   jasf_csr_regs u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   jasf_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_beat  (req_beat),
      .req_ready (req_ready),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_beat   (in_beat)
   );

   jasf_walker #(
      .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
   ) u_walker (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .step     (step),
      .beat     (in_beat),
      .result   (walker_result),
      .answered (walker_answered)
   );

   jasf_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (walker_result),
      .rsp_ready (rsp_chan.ready),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_beat  (rsp_beat)
   );

   assign rsp_chan.valid          = rsp_valid;
   assign rsp_chan.outcome        = rsp_beat.outcome;
   assign rsp_chan.payload_offset = rsp_beat.payload_offset;
   assign rsp_chan.payload_length = rsp_beat.payload_length;

`ifndef SYNTHESIS
   a_last_clears_answer: assert property (@(posedge clock) disable iff (reset)
      step && in_beat.last_byte |=> !walker_answered)
      else $error("answer flag survived end of buffer");

   a_single_answer: assert property (@(posedge clock) disable iff (reset)
      step && walker_answered |-> !walker_result.valid)
      else $error("second answer in one buffer");

   a_last_always_answers: assert property (@(posedge clock) disable iff (reset)
      step && in_beat.last_byte && !walker_answered |-> walker_result.valid)
      else $error("buffer ended without an answer");

   a_answer_reaches_port: assert property (@(posedge clock) disable iff (reset)
      step && walker_result.valid |=>
         rsp_chan.valid && rsp_chan.outcome == $past(walker_result.beat.outcome))
      else $error("answer lost on the way to the rsp port");
`endif

endmodule
